// ===== hdl/kstc_pkg.sv =====
package kstc_pkg;

	localparam int ENTRIES_DEF  = 16;
	localparam int TAG_BITS_DEF = 16;

	localparam int COUNT_W  = 31;
	localparam int TAG_IN_W = 16;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 40;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BAD_TAG = 3'd1,
		ST_ZERO    = 3'd2,
		ST_ABSENT  = 3'd3,
		ST_FULL    = 3'd4,
		ST_SAT     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_CALC,
		S_OUT
	} state_t;

endpackage

// ===== hdl/keyed_stack_count_table.sv =====
// channel  | dir | handshake          | payload
// s_*      | in  | s_tvalid/s_tready  | request item
// m_*      | out | m_tvalid/m_tready  | result item
//
// for each request the tag memory is scanned one slot a cycle through its single
// registered read port, then one shared add/subtract unit updates the count and
// writes it back
// an invalid tag skips the scan and shows its result in the next cycle
// arst_n clears all slot valid bits at once; tag and count memories are not cleared
// s_tready is high only while idle; a result holds in m_tdata until m_tready
module keyed_stack_count_table #(
	parameter int ENTRIES  = kstc_pkg::ENTRIES_DEF,
	parameter int TAG_BITS = kstc_pkg::TAG_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// func, tag, amount
	input  logic [kstc_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// count_after, status, zero fill
	output logic [kstc_pkg::OUT_W-1:0] m_tdata
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CW    = kstc_pkg::COUNT_W;

	kstc_pkg::state_t state_q, state_d;

	logic                func_q;
	logic [TAG_BITS-1:0] key_q;
	logic [CW-1:0]       amt_q;
	logic [TAG_BITS-1:0] key_d;

	logic [IDX_W-1:0]    scan_q;
	logic                cmp_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [TAG_BITS-1:0] rd_tag_s1;
	logic [CW-1:0]       rd_cnt_s1;

	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [CW-1:0]       hit_cnt_q;
	logic                free_q;
	logic [IDX_W-1:0]    free_idx_q;

	logic [ENTRIES-1:0]  valid_q;

	logic [TAG_BITS-1:0] tag_mem [ENTRIES];
	logic [CW-1:0]       cnt_mem [ENTRIES];

	logic [CW-1:0]       res_cnt_q;
	kstc_pkg::status_t   res_st_q;

	logic                accept;
	logic                key_zero;
	logic [CW:0]         au_res;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_wa;
	logic [CW-1:0]       mem_wcnt;
	logic                set_v;
	logic                clr_v;
	logic [CW-1:0]       calc_cnt;
	kstc_pkg::status_t   calc_st;

	always_comb begin
		for (int i = 0; i < TAG_BITS; i++) begin
			key_d[i] = (i < kstc_pkg::TAG_IN_W) ? s_tdata[1+i] : 1'b0;
		end
	end

	assign accept   = s_tvalid && s_tready;
	assign key_zero = (key_d == '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kstc_pkg::S_IDLE: begin
				if (accept) begin
					state_d = key_zero ? kstc_pkg::S_OUT : kstc_pkg::S_SCAN;
				end
			end
			kstc_pkg::S_SCAN: begin
				if (scan_q == IDX_W'(ENTRIES - 1)) begin
					state_d = kstc_pkg::S_DRAIN;
				end
			end
			kstc_pkg::S_DRAIN: state_d = kstc_pkg::S_CALC;
			kstc_pkg::S_CALC:  state_d = kstc_pkg::S_OUT;
			kstc_pkg::S_OUT: begin
				if (m_tready) begin
					state_d = kstc_pkg::S_IDLE;
				end
			end
			default: state_d = kstc_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			kstc_pkg::S_IDLE: s_tready = 1'b1;
			kstc_pkg::S_OUT:  m_tvalid = 1'b1;
			default: begin
				s_tready = 1'b0;
				m_tvalid = 1'b0;
			end
		endcase
	end

	assign m_tdata = {{(kstc_pkg::OUT_W - CW - 3){1'b0}}, res_st_q, res_cnt_q};

	// shared add/subtract unit
	assign au_res = func_q ? ({1'b0, hit_cnt_q} - {1'b0, amt_q})
	                       : ({1'b0, hit_cnt_q} + {1'b0, amt_q});

	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = hit_idx_q;
		mem_wcnt = au_res[CW-1:0];
		set_v    = 1'b0;
		clr_v    = 1'b0;
		calc_cnt = '0;
		calc_st  = kstc_pkg::ST_OK;
		if (amt_q == '0) begin
			calc_st  = kstc_pkg::ST_ZERO;
			calc_cnt = hit_q ? hit_cnt_q : '0;
		end else if (!func_q) begin
			if (hit_q) begin
				mem_we = 1'b1;
				if (au_res[CW]) begin
					mem_wcnt = kstc_pkg::COUNT_MAX;
					calc_st  = kstc_pkg::ST_SAT;
				end
				calc_cnt = mem_wcnt;
			end else if (free_q) begin
				mem_we   = 1'b1;
				mem_wa   = free_idx_q;
				mem_wcnt = amt_q;
				set_v    = 1'b1;
				calc_cnt = amt_q;
			end else begin
				calc_st = kstc_pkg::ST_FULL;
			end
		end else begin
			if (!hit_q) begin
				calc_st = kstc_pkg::ST_ABSENT;
			end else if (au_res[CW] || (au_res[CW-1:0] == '0)) begin
				clr_v = 1'b1;
			end else begin
				mem_we   = 1'b1;
				calc_cnt = au_res[CW-1:0];
			end
		end
	end

	// slot memories
	always_ff @(posedge clk) begin
		if (mem_we && (state_q == kstc_pkg::S_CALC)) begin
			tag_mem[mem_wa] <= key_q;
			cnt_mem[mem_wa] <= mem_wcnt;
		end
		rd_tag_s1 <= tag_mem[scan_q];
		rd_cnt_s1 <= cnt_mem[scan_q];
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (accept) begin
			func_q <= s_tdata[0];
			key_q  <= key_d;
			amt_q  <= s_tdata[kstc_pkg::IN_W-1:1+kstc_pkg::TAG_IN_W];
		end
		if (cmp_s1 && valid_q[idx_s1] && (rd_tag_s1 == key_q)) begin
			hit_idx_q <= idx_s1;
			hit_cnt_q <= rd_cnt_s1;
		end
		if (cmp_s1 && !valid_q[idx_s1] && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (accept && key_zero) begin
			res_cnt_q <= '0;
			res_st_q  <= kstc_pkg::ST_BAD_TAG;
		end else if (state_q == kstc_pkg::S_CALC) begin
			res_cnt_q <= calc_cnt;
			res_st_q  <= calc_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kstc_pkg::S_IDLE;
			scan_q  <= '0;
			cmp_s1  <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			cmp_s1  <= (state_q == kstc_pkg::S_SCAN);
			if (state_q == kstc_pkg::S_SCAN) begin
				scan_q <= scan_q + IDX_W'(1);
			end else begin
				scan_q <= '0;
			end
			if (accept) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (cmp_s1) begin
				if (valid_q[idx_s1] && (rd_tag_s1 == key_q)) begin
					hit_q <= 1'b1;
				end
				if (!valid_q[idx_s1]) begin
					free_q <= 1'b1;
				end
			end
			if (state_q == kstc_pkg::S_CALC) begin
				if (set_v) begin
					valid_q[free_idx_q] <= 1'b1;
				end
				if (clr_v) begin
					valid_q[hit_idx_q] <= 1'b0;
				end
			end
		end
	end

endmodule
